// File: rtl/tmq_pkg.sv
package tmq_pkg;

    localparam int NUM_QUEUES_DEF   = 8;
    localparam int MAX_MESSAGES_DEF = 8;
    localparam int MAX_BYTES_DEF    = 128;
    localparam logic [15:0] VOLUME_RESET = 16'd1024;
    localparam logic [7:0]  OPEN_MAX     = 8'd255;

    typedef enum logic [1:0] {
        K_OPEN  = 2'd0,
        K_CLOSE = 2'd1,
        K_WRITE = 2'd2,
        K_READ  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_OPEN  = 3'd1,
        ST_EXISTS    = 3'd2,
        ST_BAD_FLAGS = 3'd3,
        ST_FULL      = 3'd4,
        ST_NO_MATCH  = 3'd5,
        ST_TOO_LONG  = 3'd6,
        ST_BAD_QUEUE = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COPY,
        S_RD_ADDR,
        S_RD_DATA
    } t_state;

    typedef struct packed {
        logic [31:0] typ;
        logic [7:0]  size;
    } t_slot;

    typedef struct packed {
        logic load;
        logic shift;
        logic take_free;
    } t_cell_ctl;

    typedef struct packed {
        t_status     status;
        logic [3:0]  handle;
        logic [7:0]  length;
        logic [63:0] data_word_res;
        logic        last;
    } t_result;

endpackage

// File: rtl/tmq_req_if.sv
interface tmq_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [3:0]         queue_id;
    logic               create;
    logic               exclusive;
    logic               no_error;
    logic signed [31:0] msg_type;
    logic [7:0]         size;
    logic [63:0]        data_word;
    logic               data_last;

    modport source (output valid, kind, queue_id, create, exclusive, no_error, msg_type,
                    size, data_word, data_last, input ready);
    modport sink (input valid, kind, queue_id, create, exclusive, no_error, msg_type,
                  size, data_word, data_last, output ready);
endinterface

// File: rtl/tmq_res_if.sv
interface tmq_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  handle;
    logic [7:0]  length;
    logic [63:0] data_word_res;
    logic        last;

    modport source (output valid, status, handle, length, data_word_res, last, input ready);
    modport sink (input valid, status, handle, length, data_word_res, last, output ready);
endinterface

// File: rtl/tmq_cfg_if.sv
interface tmq_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] volume_limit;

    modport source (output valid, volume_limit, input ready);
    modport sink (input valid, volume_limit, output ready);
endinterface

// File: rtl/typed_message_queue_engine.sv
// Typed message queue engine. Requests come in as words on i_in, results leave as
// words on o_out, and the queue capacity for newly created queues is written on
// i_cfg; the user writes it only while the block is idle, which the block itself
// does not enforce. Each queue keeps its messages in a row of slot cells (type,
// size, buffer pointer) in arrival order; a read picks the first cell whose type
// matches, every later cell hands its contents to its lower neighbor at once, and
// the freed buffer pointer drops to the end of the row, so payload never moves.
// Payloads sit in a single-port-per-side RAM, one buffer of ceil(MAX_BYTES/8)
// words per slot; write words gather in a staging RAM first. A successful write
// commit copies the staging RAM into the payload buffer through the payload RAM
// write port, one word per cycle. A successful read delivers each word through a
// registered RAM read, then the output register. Input is held off while a copy or
// a read stream runs and while a result waits in the output register. No clearing
// pass is needed after reset.
module typed_message_queue_engine #(
    parameter int NUM_QUEUES   = tmq_pkg::NUM_QUEUES_DEF,
    parameter int MAX_MESSAGES = tmq_pkg::MAX_MESSAGES_DEF,
    parameter int MAX_BYTES    = tmq_pkg::MAX_BYTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tmq_req_if.sink   i_in,
    tmq_res_if.source o_out,
    tmq_cfg_if.sink   i_cfg
);
    localparam int SW   = (MAX_BYTES + 7) / 8;              // words per buffer
    localparam int NBUF = NUM_QUEUES * MAX_MESSAGES;
    localparam int QW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW   = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1;
    localparam int CW   = $clog2(MAX_MESSAGES + 1);
    localparam int BW   = (NBUF > 1) ? $clog2(NBUF) : 1;
    localparam int AW   = (NBUF * SW > 1) ? $clog2(NBUF * SW) : 1;
    localparam int SWW  = (SW > 1) ? $clog2(SW) : 1;

    // control state
    tmq_pkg::t_state  r_state, n_state;
    logic             r_ovalid, n_ovalid;
    tmq_pkg::t_result r_out, n_out;
    logic [15:0]      r_volume, n_volume;
    logic [7:0]       r_oc [NUM_QUEUES];
    logic [7:0]       n_oc [NUM_QUEUES];
    logic [15:0]      r_limit [NUM_QUEUES];
    logic [15:0]      n_limit [NUM_QUEUES];
    logic [15:0]      r_used [NUM_QUEUES];
    logic [15:0]      n_used [NUM_QUEUES];
    logic [CW-1:0]    r_cnt [NUM_QUEUES];
    logic [CW-1:0]    n_cnt [NUM_QUEUES];
    logic [4:0]       r_stg_cnt, n_stg_cnt;
    logic [4:0]       r_copy_n, n_copy_n;
    logic [BW-1:0]    r_buf, n_buf;
    logic [4:0]       r_w, n_w;
    logic [4:0]       r_words, n_words;
    logic [7:0]       r_len, n_len;
    logic             r_wv, n_wv;
    logic [4:0]       r_widx, n_widx;

    // slot cells
    tmq_pkg::t_slot   w_slot [NUM_QUEUES][MAX_MESSAGES];
    logic [PW-1:0]    w_ptr  [NUM_QUEUES][MAX_MESSAGES];
    tmq_pkg::t_slot   w_new;

    // request decode
    logic             w_acc, w_out_free, w_qv, w_commit, w_rd_ok;
    logic [QW-1:0]    w_qi;
    logic [7:0]       w_oc;
    logic [15:0]      w_limit, w_used;
    logic [CW-1:0]    w_cnt;
    logic             w_found_any;
    logic [PW-1:0]    w_found;
    logic [7:0]       w_slen, w_len;
    logic [4:0]       w_words;
    logic [4:0]       w_stg_next;
    tmq_pkg::t_status w_wst;

    // memories
    logic             w_stg_we, w_stg_re, w_pay_re;
    logic [63:0]      w_stg_rdata, w_pay_rdata, w_pay_wdata;
    logic [AW-1:0]    w_base, w_pay_raddr, w_pay_waddr;
    logic [7:0]       w_rem;
    logic [63:0]      w_mask_word;

    assign w_out_free = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_state == tmq_pkg::S_IDLE) && w_out_free;
    assign w_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign w_qv    = ({1'b0, i_in.queue_id} < 5'(NUM_QUEUES));
    assign w_qi    = i_in.queue_id[QW-1:0];
    assign w_oc    = r_oc[w_qi];
    assign w_limit = r_limit[w_qi];
    assign w_used  = r_used[w_qi];
    assign w_cnt   = r_cnt[w_qi];
    assign w_new   = '{typ: i_in.msg_type, size: i_in.size};

    // oldest matching message in the addressed row
    always_comb begin
        w_found_any = 1'b0;
        w_found     = '0;
        for (int i = MAX_MESSAGES - 1; i >= 0; i--) begin
            if ((w_slot[w_qi][i].typ == i_in.msg_type) && (CW'(i) < w_cnt)) begin
                w_found_any = 1'b1;
                w_found     = PW'(i);
            end
        end
    end

    assign w_slen  = w_slot[w_qi][w_found].size;
    assign w_len   = (w_slen > i_in.size) ? i_in.size : w_slen;
    assign w_words = 5'((9'(w_len) + 9'd7) >> 3);
    assign w_stg_next = (r_stg_cnt < 5'(SW)) ? r_stg_cnt + 5'd1 : r_stg_cnt;

    // write commit status
    always_comb begin
        if (!w_qv) begin
            w_wst = tmq_pkg::ST_BAD_QUEUE;
        end else if (w_oc == 8'd0) begin
            w_wst = tmq_pkg::ST_NOT_OPEN;
        end else if ({1'b0, i_in.size} > 9'(MAX_BYTES)) begin
            w_wst = tmq_pkg::ST_TOO_LONG;
        end else if (((w_limit - w_used) < {8'd0, i_in.size}) ||
                     (w_cnt >= CW'(MAX_MESSAGES))) begin
            w_wst = tmq_pkg::ST_FULL;
        end else begin
            w_wst = tmq_pkg::ST_OK;
        end
    end

    assign w_commit = w_acc && (tmq_pkg::t_kind'(i_in.kind) == tmq_pkg::K_WRITE) &&
                      i_in.data_last && (w_wst == tmq_pkg::ST_OK);
    assign w_rd_ok  = w_acc && (tmq_pkg::t_kind'(i_in.kind) == tmq_pkg::K_READ) && w_qv &&
                      (w_oc != 8'd0) && w_found_any &&
                      !((w_slen > i_in.size) && !i_in.no_error);

    // the chain: each cell takes from its upper neighbor on removal
    for (genvar gq = 0; gq < NUM_QUEUES; gq++) begin : g_row
        for (genvar gi = 0; gi < MAX_MESSAGES; gi++) begin : g_cell
            tmq_pkg::t_cell_ctl w_ctl;
            tmq_pkg::t_slot     w_nxt;
            logic [PW-1:0]      w_nxt_ptr;
            logic               w_here;

            assign w_here = (w_qi == QW'(gq));
            assign w_ctl.load      = w_commit && w_here && (w_cnt == CW'(gi));
            assign w_ctl.shift     = w_rd_ok && w_here && (PW'(gi) >= w_found) &&
                                     (CW'(gi + 1) < w_cnt);
            assign w_ctl.take_free = w_rd_ok && w_here && (CW'(gi + 1) == w_cnt);

            if (gi < MAX_MESSAGES - 1) begin : g_nb
                assign w_nxt     = w_slot[gq][gi + 1];
                assign w_nxt_ptr = w_ptr[gq][gi + 1];
            end else begin : g_end
                assign w_nxt     = w_slot[gq][gi];
                assign w_nxt_ptr = w_ptr[gq][gi];
            end

            tmq_cell #(
                .PW      (PW),
                .RST_PTR (gi)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_new      (w_new),
                .i_next     (w_nxt),
                .i_next_ptr (w_nxt_ptr),
                .i_free_ptr (w_ptr[gq][w_found]),
                .o_slot     (w_slot[gq][gi]),
                .o_ptr      (w_ptr[gq][gi])
            );
        end
    end

    // next state and outputs
    always_comb begin
        n_state   = r_state;
        n_ovalid  = r_ovalid;
        n_out     = r_out;
        n_volume  = r_volume;
        n_oc      = r_oc;
        n_limit   = r_limit;
        n_used    = r_used;
        n_cnt     = r_cnt;
        n_stg_cnt = r_stg_cnt;
        n_copy_n  = r_copy_n;
        n_buf     = r_buf;
        n_w       = r_w;
        n_words   = r_words;
        n_len     = r_len;
        n_wv      = 1'b0;
        n_widx    = r_widx;
        w_stg_we  = 1'b0;
        w_stg_re  = 1'b0;
        w_pay_re  = 1'b0;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end
        if (i_cfg.valid) begin
            n_volume = i_cfg.volume_limit;
        end

        case (r_state)
            tmq_pkg::S_IDLE: begin
                if (w_acc) begin
                    // default result: one status word
                    n_out = '{status: tmq_pkg::ST_OK, handle: 4'd0, length: 8'd0,
                              data_word_res: 64'd0, last: 1'b1};
                    n_ovalid = 1'b1;
                    case (tmq_pkg::t_kind'(i_in.kind))
                        tmq_pkg::K_WRITE: begin
                            if (r_stg_cnt < 5'(SW)) begin
                                w_stg_we = 1'b1;
                            end
                            n_stg_cnt = w_stg_next;
                            if (!i_in.data_last) begin
                                n_ovalid = r_ovalid && !o_out.ready;
                                n_out    = r_out;
                            end else begin
                                n_stg_cnt    = 5'd0;
                                n_out.status = w_wst;
                                if (w_wst == tmq_pkg::ST_OK) begin
                                    n_used[w_qi] = w_used + {8'd0, i_in.size};
                                    n_cnt[w_qi]  = w_cnt + CW'(1);
                                    n_buf    = BW'(w_qi) * BW'(MAX_MESSAGES) +
                                               BW'(w_ptr[w_qi][w_cnt[PW-1:0]]);
                                    n_copy_n = w_stg_next;
                                    n_w      = 5'd0;
                                    n_state  = tmq_pkg::S_COPY;
                                end
                            end
                        end
                        tmq_pkg::K_OPEN: begin
                            if (!w_qv) begin
                                n_out.status = tmq_pkg::ST_BAD_QUEUE;
                            end else if (!i_in.create && i_in.exclusive) begin
                                n_out.status = tmq_pkg::ST_BAD_FLAGS;
                            end else if (!i_in.create && (w_oc == 8'd0)) begin
                                n_out.status = tmq_pkg::ST_NOT_OPEN;
                            end else if (i_in.exclusive && (w_oc != 8'd0)) begin
                                n_out.status = tmq_pkg::ST_EXISTS;
                            end else begin
                                if (w_oc == 8'd0) begin
                                    n_limit[w_qi] = r_volume;
                                    n_used[w_qi]  = 16'd0;
                                    n_cnt[w_qi]   = '0;
                                end
                                if (w_oc != tmq_pkg::OPEN_MAX) begin
                                    n_oc[w_qi] = w_oc + 8'd1;
                                end
                                n_out.handle = i_in.queue_id;
                            end
                        end
                        tmq_pkg::K_CLOSE: begin
                            if (!w_qv) begin
                                n_out.status = tmq_pkg::ST_BAD_QUEUE;
                            end else if (w_oc == 8'd0) begin
                                n_out.status = tmq_pkg::ST_NOT_OPEN;
                            end else begin
                                n_oc[w_qi] = w_oc - 8'd1;
                                if (w_oc == 8'd1) begin
                                    // last user gone: queue cleared
                                    n_limit[w_qi] = 16'd0;
                                    n_used[w_qi]  = 16'd0;
                                    n_cnt[w_qi]   = '0;
                                end
                            end
                        end
                        tmq_pkg::K_READ: begin
                            if (!w_qv) begin
                                n_out.status = tmq_pkg::ST_BAD_QUEUE;
                            end else if (w_oc == 8'd0) begin
                                n_out.status = tmq_pkg::ST_NOT_OPEN;
                            end else if (!w_found_any) begin
                                n_out.status = tmq_pkg::ST_NO_MATCH;
                            end else if ((w_slen > i_in.size) && !i_in.no_error) begin
                                n_out.status = tmq_pkg::ST_TOO_LONG;
                            end else begin
                                // removal frees the full stored size
                                n_used[w_qi] = (w_used >= {8'd0, w_slen}) ?
                                               w_used - {8'd0, w_slen} : 16'd0;
                                n_cnt[w_qi] = w_cnt - CW'(1);
                                n_buf   = BW'(w_qi) * BW'(MAX_MESSAGES) +
                                          BW'(w_ptr[w_qi][w_found]);
                                n_len   = w_len;
                                n_words = w_words;
                                n_w     = 5'd0;
                                if (w_words != 5'd0) begin
                                    n_ovalid = r_ovalid && !o_out.ready;
                                    n_out    = r_out;
                                    n_state  = tmq_pkg::S_RD_ADDR;
                                end
                            end
                        end
                        default: begin
                            n_out = r_out;
                        end
                    endcase
                end
            end
            tmq_pkg::S_COPY: begin
                // one staging word read per cycle, written to the buffer in the following cycle
                if (r_w < 5'(SW)) begin
                    w_stg_re = 1'b1;
                    n_wv     = 1'b1;
                    n_widx   = r_w;
                    n_w      = r_w + 5'd1;
                end else begin
                    n_state = tmq_pkg::S_IDLE;
                end
            end
            tmq_pkg::S_RD_ADDR: begin
                w_pay_re = 1'b1;
                n_state  = tmq_pkg::S_RD_DATA;
            end
            tmq_pkg::S_RD_DATA: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_out = '{status: tmq_pkg::ST_OK, handle: 4'd0, length: r_len,
                              data_word_res: w_mask_word,
                              last: ((r_w + 5'd1) == r_words)};
                    n_w = r_w + 5'd1;
                    n_state = ((r_w + 5'd1) == r_words) ? tmq_pkg::S_IDLE
                                                        : tmq_pkg::S_RD_ADDR;
                end
            end
            default: begin
                n_state = tmq_pkg::S_IDLE;
            end
        endcase
    end

    // bytes at or past the delivered length read as zero
    assign w_rem = r_len - {r_w, 3'b000};
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            w_mask_word[b*8 +: 8] = (8'(b) < w_rem) ? w_pay_rdata[b*8 +: 8] : 8'd0;
        end
    end

    assign w_base      = AW'(r_buf) * AW'(SW);
    assign w_pay_raddr = w_base + AW'(r_w);
    assign w_pay_waddr = w_base + AW'(r_widx);
    // missing words of a short message are stored as zero
    assign w_pay_wdata = (r_widx < r_copy_n) ? w_stg_rdata : 64'd0;

    tmq_ram #(
        .WIDTH (64),
        .DEPTH (SW)
    ) u_stage (
        .i_clk   (i_clk),
        .i_we    (w_stg_we),
        .i_waddr (r_stg_cnt[SWW-1:0]),
        .i_wdata (i_in.data_word),
        .i_re    (w_stg_re),
        .i_raddr (r_w[SWW-1:0]),
        .o_rdata (w_stg_rdata)
    );

    tmq_ram #(
        .WIDTH (64),
        .DEPTH (NBUF * SW)
    ) u_payload (
        .i_clk   (i_clk),
        .i_we    (r_wv),
        .i_waddr (w_pay_waddr),
        .i_wdata (w_pay_wdata),
        .i_re    (w_pay_re),
        .i_raddr (w_pay_raddr),
        .o_rdata (w_pay_rdata)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tmq_pkg::S_IDLE;
            r_ovalid  <= 1'b0;
            r_volume  <= tmq_pkg::VOLUME_RESET;
            r_stg_cnt <= 5'd0;
            r_wv      <= 1'b0;
            r_w       <= 5'd0;
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_oc[q]    <= 8'd0;
                r_limit[q] <= 16'd0;
                r_used[q]  <= 16'd0;
                r_cnt[q]   <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_ovalid  <= n_ovalid;
            r_volume  <= n_volume;
            r_stg_cnt <= n_stg_cnt;
            r_wv      <= n_wv;
            r_w       <= n_w;
            r_oc      <= n_oc;
            r_limit   <= n_limit;
            r_used    <= n_used;
            r_cnt     <= n_cnt;
        end
    end

    // payload and bookkeeping registers
    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_copy_n <= n_copy_n;
        r_buf    <= n_buf;
        r_words  <= n_words;
        r_len    <= n_len;
        r_widx   <= n_widx;
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.status        = r_out.status;
    assign o_out.handle        = r_out.handle;
    assign o_out.length        = r_out.length;
    assign o_out.data_word_res = r_out.data_word_res;
    assign o_out.last          = r_out.last;
endmodule

// File: rtl/tmq_ram.sv
module tmq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/tmq_cell.sv
module tmq_cell #(
    parameter int PW = 3,
    parameter int RST_PTR = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tmq_pkg::t_cell_ctl i_ctl,
    input  tmq_pkg::t_slot    i_new,
    input  tmq_pkg::t_slot    i_next,
    input  logic [PW-1:0]     i_next_ptr,
    input  logic [PW-1:0]     i_free_ptr,
    output tmq_pkg::t_slot    o_slot,
    output logic [PW-1:0]     o_ptr
);
    tmq_pkg::t_slot r_slot;
    logic [PW-1:0]  r_ptr;

    // slot contents, taken from the new word or shifted down from the neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_slot <= i_next;
        end else if (i_ctl.load) begin
            r_slot <= i_new;
        end
    end

    // buffer pointers stay a permutation of the queue's buffers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= PW'(RST_PTR);
        end else if (i_ctl.shift) begin
            r_ptr <= i_next_ptr;
        end else if (i_ctl.take_free) begin
            r_ptr <= i_free_ptr;
        end
    end

    assign o_slot = r_slot;
    assign o_ptr  = r_ptr;
endmodule

// File: sim/typed_message_queue_engine_tb.sv
`timescale 1ns / 100ps

module typed_message_queue_engine_tb;
    import tmq_pkg::*;

    localparam int NQ      = NUM_QUEUES_DEF;
    localparam int NMSG    = MAX_MESSAGES_DEF;
    localparam int NBYTES  = MAX_BYTES_DEF;
    localparam int NWORDS  = (NBYTES + 7) / 8;
    localparam int DRAIN   = 2 * NWORDS + 24;

    typedef struct {
        t_kind              kind;
        logic [3:0]         qid;
        logic               cr;
        logic               ex;
        logic               ne;
        logic signed [31:0] mtype;
        logic [7:0]         size;
        logic [63:0]        data;
        logic               dlast;
    } t_request;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tmq_req_if req_if();
    tmq_res_if res_if();
    tmq_cfg_if cfg_if();

    typed_message_queue_engine i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if),
        .i_cfg   (cfg_if)
    );

    always #5 i_clk = ~i_clk;

    // mailbox state as the predictor sees it
    logic [15:0] capacity_reg;
    logic [7:0]  users      [NQ];
    logic [15:0] queue_cap  [NQ];
    logic [15:0] queue_used [NQ];
    int          queue_msgs [NQ];
    logic [31:0] msg_kind   [NQ][NMSG];
    logic [7:0]  msg_bytes  [NQ][NMSG];
    logic [63:0] msg_words  [NQ][NMSG][NWORDS];
    logic [63:0] gather_buf [NWORDS];
    int          gather_len;

    t_result pending_results[$];
    int      errors;
    int      items_sent;
    bit      steady;      // no idling on either side
    int      rx_hold;     // long receiver hold-off, in cycles
    int      rx_wait;

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    task automatic expect_word(input t_status st, input logic [3:0] hd, input logic [7:0] len,
                               input logic [63:0] w, input logic lst);
        t_result r;
        r.status        = st;
        r.handle        = hd;
        r.length        = len;
        r.data_word_res = w;
        r.last          = lst;
        pending_results.push_back(r);
    endtask

    // mailbox predictor: updates the state and queues the result words of one request
    task automatic predict_results(input t_request rq);
        int      q;
        int      hit;
        int      len;
        int      nw;
        int      rem;
        t_status st;
        logic [63:0] v;
        q = rq.qid;
        if (rq.kind == K_WRITE) begin
            if (gather_len < NWORDS) begin
                gather_buf[gather_len] = rq.data;
                gather_len++;
            end
            if (!rq.dlast) return;
            st = ST_OK;
            if (q >= NQ) st = ST_BAD_QUEUE;
            else if (users[q] == 0) st = ST_NOT_OPEN;
            else if (rq.size > NBYTES) st = ST_TOO_LONG;
            else if (int'(queue_cap[q]) - int'(queue_used[q]) < int'(rq.size) ||
                     queue_msgs[q] >= NMSG) st = ST_FULL;
            if (st == ST_OK) begin
                msg_kind[q][queue_msgs[q]]  = rq.mtype;
                msg_bytes[q][queue_msgs[q]] = rq.size;
                for (int w = 0; w < NWORDS; w++)
                    msg_words[q][queue_msgs[q]][w] = (w < gather_len) ? gather_buf[w] : 64'd0;
                queue_used[q] += rq.size;
                queue_msgs[q]++;
            end
            gather_len = 0;
            expect_word(st, 0, 0, 0, 1);
            return;
        end
        if (q >= NQ) begin
            expect_word(ST_BAD_QUEUE, 0, 0, 0, 1);
            return;
        end
        case (rq.kind)
            K_OPEN: begin
                if (!rq.cr && rq.ex) expect_word(ST_BAD_FLAGS, 0, 0, 0, 1);
                else if (!rq.cr && users[q] == 0) expect_word(ST_NOT_OPEN, 0, 0, 0, 1);
                else if (rq.cr && rq.ex && users[q] != 0) expect_word(ST_EXISTS, 0, 0, 0, 1);
                else begin
                    if (users[q] == 0) begin
                        queue_cap[q]  = capacity_reg;
                        queue_used[q] = 0;
                        queue_msgs[q] = 0;
                    end
                    if (users[q] < OPEN_MAX) users[q]++;
                    expect_word(ST_OK, q[3:0], 0, 0, 1);
                end
            end
            K_CLOSE: begin
                if (users[q] == 0) expect_word(ST_NOT_OPEN, 0, 0, 0, 1);
                else begin
                    users[q]--;
                    if (users[q] == 0) begin
                        queue_cap[q]  = 0;
                        queue_used[q] = 0;
                        queue_msgs[q] = 0;
                    end
                    expect_word(ST_OK, 0, 0, 0, 1);
                end
            end
            default: begin
                if (users[q] == 0) begin
                    expect_word(ST_NOT_OPEN, 0, 0, 0, 1);
                    return;
                end
                // oldest message of the requested type
                hit = -1;
                for (int i = 0; i < queue_msgs[q]; i++)
                    if (hit < 0 && msg_kind[q][i] == rq.mtype) hit = i;
                if (hit < 0) begin
                    expect_word(ST_NO_MATCH, 0, 0, 0, 1);
                    return;
                end
                len = msg_bytes[q][hit];
                if (len > rq.size) begin
                    if (!rq.ne) begin
                        expect_word(ST_TOO_LONG, 0, 0, 0, 1);
                        return;
                    end
                    len = rq.size;   // truncated delivery
                end
                nw = (len + 7) / 8;
                if (nw == 0) expect_word(ST_OK, 0, 0, 0, 1);
                for (int w = 0; w < nw; w++) begin
                    v   = msg_words[q][hit][w];
                    rem = len - w * 8;
                    if (rem < 8) v &= (64'd1 << (rem * 8)) - 64'd1;
                    expect_word(ST_OK, 0, len[7:0], v, w + 1 == nw);
                end
                // the full stored size is freed even when truncated
                if (queue_used[q] >= msg_bytes[q][hit]) queue_used[q] -= msg_bytes[q][hit];
                else queue_used[q] = 0;
                for (int i = hit; i + 1 < queue_msgs[q]; i++) begin
                    msg_kind[q][i]  = msg_kind[q][i + 1];
                    msg_bytes[q][i] = msg_bytes[q][i + 1];
                    msg_words[q][i] = msg_words[q][i + 1];
                end
                queue_msgs[q]--;
            end
        endcase
    endtask

    // offer one request word, wait for acceptance, then predict
    task automatic send_word(input t_request rq);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.kind      <= rq.kind;
        req_if.queue_id  <= rq.qid;
        req_if.create    <= rq.cr;
        req_if.exclusive <= rq.ex;
        req_if.no_error  <= rq.ne;
        req_if.msg_type  <= rq.mtype;
        req_if.size      <= rq.size;
        req_if.data_word <= rq.data;
        req_if.data_last <= rq.dlast;
        req_if.valid     <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (req_if.ready === 1'b1) break;
        end
        predict_results(rq);
        items_sent++;
    endtask

    function automatic t_request blank_req(input t_kind k, input logic [3:0] q);
        t_request rq;
        rq.kind  = k;
        rq.qid   = q;
        rq.cr    = 1'($urandom_range(0, 1));
        rq.ex    = 1'($urandom_range(0, 1));
        rq.ne    = 1'($urandom_range(0, 1));
        rq.mtype = $urandom;
        rq.size  = 8'($urandom);
        rq.data  = {$urandom, $urandom};
        rq.dlast = 1'b1;
        return rq;
    endfunction

    task automatic open_queue(input logic [3:0] q, input logic cr, input logic ex);
        t_request rq;
        rq    = blank_req(K_OPEN, q);
        rq.cr = cr;
        rq.ex = ex;
        send_word(rq);
    endtask

    task automatic close_queue(input logic [3:0] q);
        send_word(blank_req(K_CLOSE, q));
    endtask

    // a message of nw payload words, the last one flagged
    task automatic post_message(input logic [3:0] q, input logic signed [31:0] mt,
                                input logic [7:0] sz, input int nw);
        t_request rq;
        for (int i = 0; i < nw; i++) begin
            rq       = blank_req(K_WRITE, q);
            rq.mtype = mt;
            rq.size  = sz;
            rq.dlast = (i == nw - 1);
            send_word(rq);
        end
    endtask

    task automatic fetch_message(input logic [3:0] q, input logic signed [31:0] mt,
                                 input logic [7:0] sz, input logic ne);
        t_request rq;
        rq       = blank_req(K_READ, q);
        rq.mtype = mt;
        rq.size  = sz;
        rq.ne    = ne;
        send_word(rq);
    endtask

    // let every result drain and the block settle before touching the register
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [15:0] v);
        wait_idle();
        cfg_if.volume_limit <= v;
        cfg_if.valid        <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (cfg_if.ready === 1'b1) break;
        end
        cfg_if.valid <= 1'b0;
        capacity_reg = v;
    endtask

    // open flag combinations, bad ids and the not-open answers
    task automatic test_open_flags();
        open_queue(0, 0, 1);
        open_queue(0, 0, 0);
        close_queue(0);
        fetch_message(0, 0, 8, 0);
        post_message(0, 0, 8, 1);
        open_queue(0, 1, 1);
        open_queue(0, 1, 1);
        open_queue(0, 1, 0);
        open_queue(0, 0, 0);
        open_queue(15, 1, 0);
        close_queue(8);
        fetch_message(12, 0, 8, 1);
        post_message(15, 0, 8, 2);
    endtask

    // type extremes, empty message, no match, oversize with and without truncation
    task automatic test_read_write();
        post_message(0, 32'sh7fffffff, 128, 16);
        post_message(0, 32'sh80000000, 0, 1);
        post_message(0, -1, 13, 2);
        post_message(0, 5, 129, 17);
        post_message(0, 5, 255, 1);
        fetch_message(0, 7, 128, 0);
        fetch_message(0, 32'sh80000000, 0, 0);
        fetch_message(0, -1, 12, 0);
        fetch_message(0, -1, 5, 1);
        fetch_message(0, 32'sh7fffffff, 255, 0);
        post_message(0, 3, 24, 20);   // extra words are dropped
        post_message(0, 3, 40, 2);    // missing words read as zero
        fetch_message(0, 3, 24, 0);
        fetch_message(0, 3, 40, 0);
    endtask

    // message-count and byte-capacity limits, register extremes
    task automatic test_capacity();
        set_capacity(16'd0);
        open_queue(1, 1, 0);
        post_message(1, 9, 0, 1);
        post_message(1, 9, 1, 1);
        set_capacity(16'd40);
        open_queue(2, 1, 1);
        post_message(2, 1, 32, 4);
        post_message(2, 1, 16, 2);
        fetch_message(2, 1, 0, 1);    // truncate to nothing, frees 32
        post_message(2, 1, 16, 2);
        set_capacity(16'hffff);
        open_queue(3, 1, 0);
        for (int i = 0; i < NMSG + 1; i++) post_message(3, i, 8, 1);
        for (int i = NMSG; i >= 0; i--) fetch_message(3, i, 8, 0);
        close_queue(3);
        close_queue(3);
        set_capacity(VOLUME_RESET);
    endtask

    // receiver holds off while reads keep coming, so the block backs up
    task automatic test_backpressure();
        open_queue(4, 1, 0);
        for (int i = 0; i < 6; i++) post_message(4, 2, 16, 2);
        rx_hold = 300;
        steady  = 1;
        for (int i = 0; i < 6; i++) fetch_message(4, 2, 128, 0);
        steady = 0;
        while (rx_hold > 0) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_type();
        case ($urandom_range(0, 5))
            0: return 32'sh80000000;
            1: return 32'sh7fffffff;
            2: return $urandom;
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    // mostly well-formed traffic on a few live queues, some noise
    task automatic test_random_traffic();
        logic [3:0] q;
        logic [7:0] sz;
        int         nw;
        int         pick;
        for (int q0 = 0; q0 < NQ; q0 += 2) open_queue(4'(q0), 1, 0);
        while (items_sent < 170) begin
            q    = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(8, 15))
                                                 : 4'($urandom_range(0, NQ - 1));
            pick = $urandom_range(0, 19);
            if ($urandom_range(0, 40) == 0) steady = ~steady;
            if (pick < 8) begin
                sz = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 48));
                nw = (sz + 7) / 8;
                if (nw == 0 || $urandom_range(0, 7) == 0) nw = $urandom_range(1, 18);
                post_message(q, pick_type(), sz, nw);
            end else if (pick < 16) begin
                fetch_message(q, pick_type(), $urandom_range(0, 9) == 0 ? 8'($urandom)
                                              : 8'($urandom_range(0, 130)),
                              1'($urandom_range(0, 1)));
            end else if (pick < 18) begin
                open_queue(q, $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
            end else begin
                close_queue(q);
            end
        end
        steady = 0;
    endtask

    // long hold-off counter
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) rx_hold--;
        end
    end

    // result checker
    initial begin
        t_result want;
        res_if.ready <= 1'b0;
        rx_wait = 0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                if (pending_results.size() == 0) begin
                    report("result word with nothing expected");
                end else begin
                    want = pending_results.pop_front();
                    if (res_if.status !== want.status)
                        report($sformatf("status %0d, want %0d", res_if.status, want.status));
                    if (res_if.handle !== want.handle)
                        report($sformatf("handle %0d, want %0d", res_if.handle, want.handle));
                    if (res_if.length !== want.length)
                        report($sformatf("length %0d, want %0d", res_if.length, want.length));
                    if (res_if.data_word_res !== want.data_word_res)
                        report($sformatf("data %h, want %h", res_if.data_word_res,
                                         want.data_word_res));
                    if (res_if.last !== want.last)
                        report($sformatf("last %b, want %b", res_if.last, want.last));
                end
                rx_wait = steady ? 0 : $urandom_range(0, 7);
            end
            if (rx_hold > 0) begin
                res_if.ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        errors     = 0;
        items_sent = 0;
        steady     = 0;
        rx_hold    = 0;
        gather_len = 0;
        capacity_reg = VOLUME_RESET;
        for (int q = 0; q < NQ; q++) begin
            users[q]      = 0;
            queue_cap[q]  = 0;
            queue_used[q] = 0;
            queue_msgs[q] = 0;
        end
        i_rst_n             <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.kind         <= K_OPEN;
        req_if.queue_id     <= '0;
        req_if.create       <= 1'b0;
        req_if.exclusive    <= 1'b0;
        req_if.no_error     <= 1'b0;
        req_if.msg_type     <= '0;
        req_if.size         <= '0;
        req_if.data_word    <= '0;
        req_if.data_last    <= 1'b0;
        cfg_if.valid        <= 1'b0;
        cfg_if.volume_limit <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_open_flags();
        test_read_write();
        test_capacity();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        if (errors == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
